[rtl/sfr_pkg.sv]
`timescale 1ns / 1ps

package sfr_pkg;

	// Window depth and replacement depth
	localparam int MAX_PATTERN     = 16;
	localparam int MAX_REPLACEMENT = 16;

	// Configuration port
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int LEN_W      = 5;
	localparam int CFG_BYTES  = 2 * CFG_W / 8;

	// Derived widths
	localparam int FILL_W    = $clog2(MAX_PATTERN + 1);
	localparam int RLEN_W    = $clog2(MAX_REPLACEMENT + 1);
	localparam int RUN_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int RCNT_W    = $clog2(RUN_BYTES + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH     = 3'd0,
		REG_PATTERN_LOW        = 3'd1,
		REG_PATTERN_HIGH       = 3'd2,
		REG_REPLACEMENT_LENGTH = 3'd3,
		REG_REPLACEMENT_LOW    = 3'd4,
		REG_REPLACEMENT_HIGH   = 3'd5
	} cfg_reg_t;

	// Effective configuration, lengths already clamped
	typedef struct packed {
		logic [FILL_W-1:0]      plen;
		logic [RLEN_W-1:0]      rlen;
		logic [CFG_BYTES*8-1:0] pattern;
		logic [CFG_BYTES*8-1:0] replacement;
	} cfg_t;

	// Results released by one input transaction: count data bytes, then an
	// optional end marker
	typedef struct packed {
		logic [RUN_BYTES*8-1:0] bytes;
		logic [RCNT_W-1:0]      count;
		logic                   marker;
	} run_t;

	// Byte i of a pattern or replacement; positions past the registers read 0
	function automatic logic [7:0] cfg_byte(input logic [CFG_BYTES*8-1:0] v,
		input int unsigned i);
		if (i < CFG_BYTES) begin
			cfg_byte = v[i*8 +: 8];
		end else begin
			cfg_byte = '0;
		end
	endfunction

endpackage

[rtl/sfr_cfg_regs.sv]
`timescale 1ns / 1ps

module sfr_cfg_regs import sfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [CFG_W-1:0]     wr_data,
	output cfg_t                 cfg
);

	logic [LEN_W-1:0] plen_q;
	logic [LEN_W-1:0] rlen_q;
	logic [CFG_W-1:0] pat_lo_q;
	logic [CFG_W-1:0] pat_hi_q;
	logic [CFG_W-1:0] rep_lo_q;
	logic [CFG_W-1:0] rep_hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q   <= LEN_W'(1);
			rlen_q   <= '0;
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			rep_lo_q <= '0;
			rep_hi_q <= '0;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_PATTERN_LENGTH:     plen_q   <= wr_data[LEN_W-1:0];
				REG_PATTERN_LOW:        pat_lo_q <= wr_data;
				REG_PATTERN_HIGH:       pat_hi_q <= wr_data;
				REG_REPLACEMENT_LENGTH: rlen_q   <= wr_data[LEN_W-1:0];
				REG_REPLACEMENT_LOW:    rep_lo_q <= wr_data;
				REG_REPLACEMENT_HIGH:   rep_hi_q <= wr_data;
				default: ;
			endcase
		end
	end

	// Clamp lengths: zero pattern length acts as one, both saturate at depth
	always_comb begin
		if (plen_q == '0) begin
			cfg.plen = FILL_W'(1);
		end else if (int'(plen_q) > MAX_PATTERN) begin
			cfg.plen = FILL_W'(MAX_PATTERN);
		end else begin
			cfg.plen = FILL_W'(plen_q);
		end
		if (int'(rlen_q) > MAX_REPLACEMENT) begin
			cfg.rlen = RLEN_W'(MAX_REPLACEMENT);
		end else begin
			cfg.rlen = RLEN_W'(rlen_q);
		end
		cfg.pattern     = {pat_hi_q, pat_lo_q};
		cfg.replacement = {rep_hi_q, rep_lo_q};
	end

endmodule

[rtl/sfr_scan.sv]
`timescale 1ns / 1ps

module sfr_scan import sfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	input  cfg_t       cfg,
	output run_t       run
);

	logic [7:0]               window_q [MAX_PATTERN];
	logic [FILL_W-1:0]        fill_q;

	logic [MAX_PATTERN*8-1:0] win_vec;
	logic [MAX_PATTERN*8-1:0] win_shift;
	logic [FILL_W-1:0]        fill_a;
	logic [FILL_W-1:0]        pops;
	logic [FILL_W-1:0]        fill_n;
	logic [MAX_PATTERN-1:0]   byte_eq;
	logic                     hit;

	always_comb begin
		fill_a = fill_q + 1'b1;

		// Window with the new byte appended at the fill position
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_vec[i*8 +: 8] = (FILL_W'(i) == fill_q) ? in_byte : window_q[i];
			byte_eq[i] = (win_vec[i*8 +: 8] == cfg_byte(cfg.pattern, i)) ||
				(FILL_W'(i) >= cfg.plen);
		end
		hit = (fill_a == cfg.plen) && (&byte_eq);

		// Oldest bytes that leave the window
		if (hit) begin
			pops = '0;
		end else if (end_of_input) begin
			pops = fill_a;
		end else if (fill_a > cfg.plen) begin
			pops = fill_a - cfg.plen + 1'b1;
		end else if (fill_a == cfg.plen) begin
			pops = FILL_W'(1);
		end else begin
			pops = '0;
		end

		fill_n    = (hit || end_of_input) ? '0 : fill_a - pops;
		win_shift = win_vec >> {pops, 3'b000};

		run.bytes = '0;
		if (hit) begin
			for (int i = 0; i < MAX_REPLACEMENT; i++) begin
				run.bytes[i*8 +: 8] = cfg_byte(cfg.replacement, i);
			end
			run.count = RCNT_W'(cfg.rlen);
		end else begin
			run.bytes[MAX_PATTERN*8-1:0] = win_vec;
			run.count = RCNT_W'(pops);
		end
		run.marker = end_of_input;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < MAX_PATTERN; i++) begin
				window_q[i] <= win_shift[i*8 +: 8];
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) < MAX_PATTERN)
		else $error("window fill reached its depth");

	a_flush_empty: assert property (@(posedge clk) disable iff (!arst_n)
		accept && end_of_input |=> fill_q == '0)
		else $error("window not empty after end of stream");

	a_fill_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> fill_q < $past(cfg.plen))
		else $error("window holds a full pattern after a transaction");

endmodule

[rtl/sfr_out.sv]
`timescale 1ns / 1ps

module sfr_out import sfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  run_t       run,
	output logic       take_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       last_of_run,
	output logic       end_of_stream
);

	logic [RUN_BYTES*8-1:0] bytes_q;
	logic [RCNT_W-1:0]      count_q;
	logic                   marker_q;
	logic                   xfer;

	always_comb begin
		has_byte      = (count_q != '0);
		out_valid     = has_byte || marker_q;
		out_byte      = has_byte ? bytes_q[7:0] : '0;
		end_of_stream = !has_byte;
		last_of_run   = marker_q ? !has_byte : (count_q == RCNT_W'(1));
		xfer          = out_valid && out_ready;
		take_ready    = !out_valid || (out_ready && last_of_run);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			marker_q <= 1'b0;
		end else if (load) begin
			count_q  <= run.count;
			marker_q <= run.marker;
		end else if (xfer) begin
			if (has_byte) begin
				count_q <= count_q - 1'b1;
			end else begin
				marker_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= run.bytes;
		end else if (xfer) begin
			bytes_q <= bytes_q >> 8;
		end
	end

	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_stream |-> last_of_run)
		else $error("end marker is not the last result of its run");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && !last_of_run |-> !load ##1 out_valid)
		else $error("run cut short");

endmodule

[rtl/stream_find_and_replace_unit.sv]
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    in_byte, end_of_input
// out       out_valid / out_ready  out_byte, has_byte, last_of_run, end_of_stream
// cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One input transaction per cycle while the run register can take it; the
// scan logic sits between the window register and the run register, so a
// transaction releasing at most one result never stalls the input while the
// receiver is ready. Its result shows on the output the cycle after the input
// transaction. A transaction releasing N results holds the output run register
// until the last of them leaves; the next input transaction is taken in the
// cycle that last result leaves. Transactions releasing nothing do not stall.
// Reset empties the window and the run register and sets pattern length to
// one, all other registers to zero. cfg_ready is always high.

module stream_find_and_replace_unit import sfr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 end_of_input,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 has_byte,
	output logic                 last_of_run,
	output logic                 end_of_stream,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t cfg;
	run_t run;
	logic in_xfer;

	// Configuration writes are always accepted and land in the register set
	assign cfg_ready = 1'b1;

	// Accept when the run register is empty or its last result leaves now
	assign in_xfer = in_valid && in_ready;

	sfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Append, compare against the pattern, and pick what the transaction releases
	sfr_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_xfer),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.cfg          (cfg),
		.run          (run)
	);

	// Hold the released run and drain it one result per output transaction
	sfr_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (in_xfer),
		.run           (run),
		.take_ready    (in_ready),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.last_of_run   (last_of_run),
		.end_of_stream (end_of_stream)
	);

	a_in_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !out_valid || (out_ready && last_of_run))
		else $error("input taken while a run is still pending");

endmodule
